// ----- design/polyphonic_voice_allocator_core_assert.svh -----
// Assertion macros used by the checker file of this block.
`ifndef POLYPHONIC_VOICE_ALLOCATOR_CORE_ASSERT_SVH
`define POLYPHONIC_VOICE_ALLOCATOR_CORE_ASSERT_SVH

// A condition that must be followed in the next cycle by a consequence.
`define PVA_ASSERT_NEXT(label, clk, rst, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

// A condition that must hold at every clock edge outside reset.
`define PVA_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`endif

// ----- design/pva_pkg.sv -----
// ---------------------------------------------------------------------------
// pva_pkg
// Shared types and constants of the polyphonic voice allocator.
// ---------------------------------------------------------------------------
package pva_pkg;

  localparam int unsigned VoicesDefault   = 16;
  localparam int unsigned ChannelsDefault = 16;

  localparam logic [1:0] CMD_NOTE_ON  = 2'd0;
  localparam logic [1:0] CMD_NOTE_OFF = 2'd1;
  localparam logic [1:0] CMD_END      = 2'd2;
  localparam logic [1:0] CMD_KILL     = 2'd3;

  localparam logic [2:0] ST_FREE     = 3'd0;
  localparam logic [2:0] ST_STOLEN   = 3'd1;
  localparam logic [2:0] ST_RELEASED = 3'd2;
  localparam logic [2:0] ST_NOMATCH  = 3'd3;
  localparam logic [2:0] ST_ENDED    = 3'd4;
  localparam logic [2:0] ST_KILLED   = 3'd5;

endpackage

// ----- design/pva_ram.sv -----
// ---------------------------------------------------------------------------
// pva_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ---------------------------------------------------------------------------
module pva_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/polyphonic_voice_allocator_core.sv -----
// ---------------------------------------------------------------------------
// polyphonic_voice_allocator_core
// Voice allocator with oldest-voice stealing, built around two small RAMs.
// ---------------------------------------------------------------------------
// A command transaction is taken at a rising edge where start is high and
// busy is low. The block then raises busy until it has produced exactly one
// result, which is shown on status, voice_id, voice_count, velocity_out and
// fixed_pitch_out for one cycle while done is high. The receiver cannot stall.
// Kill, an end of an inactive voice and a note-off with no voices go straight
// to the result. A note-on without stealing makes a priority pick over the
// active flags. A note-off searches the list from the newest entry; each entry
// costs one read of the age list followed by one read of the note/channel RAM.
// A steal takes the oldest entry as its victim, and an end searches for its
// voice, one entry per cycle once the first read is primed. Both then close the
// gap, which costs one read and one write per entry behind the dropped voice in
// the age RAM. The next command can be taken in the cycle that shows the result.
// Reset returns to idle with no voices; the RAMs are not cleared, and only
// entries below the count are used.
// ---------------------------------------------------------------------------
module polyphonic_voice_allocator_core #(
  parameter int unsigned VOICES   = pva_pkg::VoicesDefault,
  parameter int unsigned CHANNELS = pva_pkg::ChannelsDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] cmd,
  input  logic [6:0] note,
  input  logic [3:0] channel,
  input  logic [6:0] velocity,
  input  logic       fixed_pitch,
  input  logic [3:0] ended_voice,
  output logic       done,
  output logic [2:0] status,
  output logic [3:0] voice_id,
  output logic [4:0] voice_count,
  output logic [6:0] velocity_out,
  output logic       fixed_pitch_out
);

  localparam int unsigned VW = $clog2(VOICES);
  localparam int unsigned CW = $clog2(VOICES + 1);

  // One-hot sequencer states.
  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_OFFA  = 8'b0000_0010, // age list entry read is in flight
    S_OFFB  = 8'b0000_0100, // note/channel read is in flight
    S_FIND  = 8'b0000_1000, // search the age list for the victim
    S_SHIFT = 8'b0001_0000, // read next entry for the gap closing
    S_SHWR  = 8'b0010_0000, // write the shifted entry one place down
    S_APP   = 8'b0100_0000, // append or finish
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t state;

  // Command registers.
  logic [1:0]    cmd_r;
  logic [6:0]    note_r;
  logic [3:0]    chan_r;
  logic [6:0]    vel_r;
  logic          fix_r;
  logic [VW-1:0] victim;     // voice being dropped or started
  logic [CW-1:0] idx;        // list position being looked at
  logic [CW-1:0] count;
  logic [VOICES-1:0] active;
  logic [VOICES-1:0] held;

  logic [2:0]    st_r;
  logic [3:0]    vid_r;

  // Voice number read from the age list, held for the note/channel compare.
  logic [VW-1:0] age_rdata_q;

  // Age list RAM.
  logic          age_we;
  logic [VW-1:0] age_waddr, age_raddr, age_rdata, age_wdata;
  // Note/channel RAM, indexed by voice.
  logic          nc_we;
  logic [VW-1:0] nc_raddr;
  logic [10:0]   nc_rdata;

  pva_ram #(.WIDTH(VW), .DEPTH(VOICES)) u_age (
    .clk(clk), .we(age_we), .waddr(age_waddr), .wdata(age_wdata),
    .raddr(age_raddr), .rdata(age_rdata)
  );

  pva_ram #(.WIDTH(11), .DEPTH(VOICES)) u_nc (
    .clk(clk), .we(nc_we), .waddr(victim), .wdata({note_r, chan_r}),
    .raddr(nc_raddr), .rdata(nc_rdata)
  );

  // Lowest free voice.
  logic [VW-1:0] free_v;
  always_comb begin
    free_v = '0;
    for (int i = VOICES - 1; i >= 0; i--) begin
      if (!active[i]) begin
        free_v = VW'(i);
      end
    end
  end

  logic [VW-1:0] end_v;
  logic          end_ok;
  assign end_v  = VW'(ended_voice);
  assign end_ok = (VOICES > 32'(ended_voice)) && active[end_v];

  assign busy = (state != S_IDLE);

  always_comb begin
    age_we     = 1'b0;
    age_waddr  = idx[VW-1:0];
    age_wdata  = age_rdata;
    age_raddr  = idx[VW-1:0];
    nc_we      = 1'b0;
    nc_raddr   = age_rdata;
    case (state)
      S_IDLE: begin
        // A note-off starts at the newest entry, every other command at the oldest.
        if (cmd == pva_pkg::CMD_NOTE_OFF) begin
          age_raddr = VW'(count - CW'(1));
        end else begin
          age_raddr = '0;
        end
      end
      S_OFFB: begin
        age_raddr = VW'(idx - CW'(1));
      end
      S_SHWR: begin
        age_we    = 1'b1;
        age_waddr = VW'(idx - CW'(1));
        age_raddr = idx[VW-1:0];
      end
      S_APP: begin
        age_we    = (cmd_r == pva_pkg::CMD_NOTE_ON);
        age_waddr = count[VW-1:0];
        age_wdata = victim;
        nc_we     = (cmd_r == pva_pkg::CMD_NOTE_ON);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      active <= '0;
      held   <= '0;
      count  <= '0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            cmd_r  <= cmd;
            note_r <= note;
            chan_r <= channel;
            vel_r  <= velocity;
            fix_r  <= fixed_pitch;
            st_r   <= pva_pkg::ST_NOMATCH;
            vid_r  <= '0;
            case (cmd)
              pva_pkg::CMD_NOTE_ON: begin
                if ({1'b0, channel} >= 5'(CHANNELS)) begin
                  state <= S_OUT;
                end else if (count == CW'(VOICES)) begin
                  st_r  <= pva_pkg::ST_STOLEN;
                  idx   <= CW'(1);
                  state <= S_FIND;  // entry 0 read is in flight
                end else begin
                  st_r   <= pva_pkg::ST_FREE;
                  victim <= free_v;
                  state  <= S_APP;
                end
              end
              pva_pkg::CMD_NOTE_OFF: begin
                if (count == '0) begin
                  state <= S_OUT;
                end else begin
                  idx   <= count - CW'(1);
                  state <= S_OFFA;
                end
              end
              pva_pkg::CMD_END: begin
                vid_r <= ended_voice;
                if (end_ok) begin
                  st_r   <= pva_pkg::ST_ENDED;
                  victim <= end_v;
                  idx    <= '0;
                  state  <= S_FIND;
                end else begin
                  state <= S_OUT;
                end
              end
              default: begin
                active <= '0;
                held   <= '0;
                count  <= '0;
                st_r   <= pva_pkg::ST_KILLED;
                state  <= S_OUT;
              end
            endcase
          end
        end
        S_OFFA: state <= S_OFFB;
        S_OFFB: begin
          if (nc_rdata == {note_r, chan_r}) begin
            held[age_rdata_q] <= 1'b0;
            st_r  <= pva_pkg::ST_RELEASED;
            vid_r <= 4'(age_rdata_q);
            state <= S_OUT;
          end else if (idx == '0) begin
            state <= S_OUT;
          end else begin
            idx   <= idx - CW'(1);
            state <= S_OFFA;
          end
        end
        S_FIND: begin
          if (cmd_r == pva_pkg::CMD_NOTE_ON) begin
            // Steal: the oldest entry is the victim; the gap is at 0.
            victim           <= age_rdata;
            active[age_rdata] <= 1'b0;
            held[age_rdata]   <= 1'b0;
            idx              <= CW'(1);
            state            <= S_SHIFT;
          end else if (idx == '0) begin
            idx   <= CW'(1);   // wait for entry 0 data
            state <= S_FIND;
            cmd_r <= pva_pkg::CMD_KILL; // changes nothing: cmd_r is not a note-on either way
          end else if (age_rdata == victim) begin
            active[victim] <= 1'b0;
            held[victim]   <= 1'b0;
            state          <= S_SHIFT;
          end else begin
            idx <= idx + CW'(1);
          end
        end
        S_SHIFT: begin
          if (idx >= count) begin
            count <= count - CW'(1);
            state <= S_APP;
          end else begin
            state <= S_SHWR;
          end
        end
        S_SHWR: begin
          idx   <= idx + CW'(1);
          state <= S_SHIFT;
        end
        S_APP: begin
          if (st_r == pva_pkg::ST_FREE || st_r == pva_pkg::ST_STOLEN) begin
            active[victim] <= 1'b1;
            held[victim]   <= 1'b1;
            count          <= count + CW'(1);
            vid_r          <= 4'(victim);
          end
          state <= S_OUT;
        end
        S_OUT: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OFFA) begin
      age_rdata_q <= age_rdata;
    end
  end

  logic started;
  assign started = (st_r == pva_pkg::ST_FREE) || (st_r == pva_pkg::ST_STOLEN);

  assign status          = st_r;
  assign voice_id        = vid_r;
  assign voice_count     = 5'(count);
  assign velocity_out    = started ? vel_r : '0;
  assign fixed_pitch_out = started & fix_r;

endmodule

// ----- design/pva_checker.sv -----
// ---------------------------------------------------------------------------
// pva_checker
// Port-level checks of the voice allocator core, bound to the top level.
// ---------------------------------------------------------------------------
`include "polyphonic_voice_allocator_core_assert.svh"

module pva_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic [2:0] status,
  input logic [3:0] voice_id,
  input logic [4:0] voice_count
);

  `PVA_ASSERT_NEXT(a_take_busy, clk, rst, start && !busy, busy, "busy not raised")
  `PVA_ASSERT_NEXT(a_done_idle, clk, rst, done, !done, "result shown twice")
  `PVA_ASSERT_ALWAYS(a_kill_zero, clk, rst,
    !(done && status == pva_pkg::ST_KILLED) || (voice_count == 5'd0 && voice_id == 4'd0),
    "kill left voices")
  `PVA_ASSERT_ALWAYS(a_status_rng, clk, rst, !done || status <= pva_pkg::ST_KILLED, "bad status")

endmodule

bind polyphonic_voice_allocator_core pva_checker u_pva_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .status(status), .voice_id(voice_id), .voice_count(voice_count)
);

// ----- tb/polyphonic_voice_allocator_core_test.sv -----
// ---------------------------------------------------------------------------
// polyphonic_voice_allocator_core_test
// Drives note-on, note-off, end and kill command transactions into the voice
// allocator and checks every result against a behavioral voice table kept in
// the testbench, plus a directed table of commands, some with known results.
// ---------------------------------------------------------------------------
module polyphonic_voice_allocator_core_test;

  localparam int NV = 16;
  localparam int NCH = 16;

  typedef struct packed {
    logic [1:0] cmd;
    logic [6:0] note;
    logic [3:0] channel;
    logic [6:0] velocity;
    logic       fixed_pitch;
    logic [3:0] ended_voice;
  } command_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] voice_id;
    logic [4:0] voice_count;
    logic [6:0] velocity_out;
    logic       fixed_pitch_out;
  } outcome_t;

  // One row of the directed table: a command, and optionally a typed-in
  // outcome that must match the prediction as well as the hardware.
  typedef struct packed {
    command_t cmd;
    logic     known;
    outcome_t res;
  } row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  logic [1:0] cmd = pva_pkg::CMD_KILL;
  logic [6:0] note = '0;
  logic [3:0] channel = '0;
  logic [6:0] velocity = '0;
  logic       fixed_pitch = 1'b0;
  logic [3:0] ended_voice = '0;
  logic       done;
  logic [2:0] status;
  logic [3:0] voice_id;
  logic [4:0] voice_count;
  logic [6:0] velocity_out;
  logic       fixed_pitch_out;

  polyphonic_voice_allocator_core uut (
    .clk, .rst, .start, .busy, .cmd, .note, .channel, .velocity, .fixed_pitch,
    .ended_voice, .done, .status, .voice_id, .voice_count, .velocity_out,
    .fixed_pitch_out
  );

  always #5 clk = ~clk;

  // Predicted voice table.
  logic [3:0] ages[NV];
  int         n_active;
  logic       is_active[NV];
  logic       is_held[NV];
  logic [6:0] v_note[NV];
  logic [3:0] v_chan[NV];

  outcome_t pending_results[$];
  int       errors = 0;
  logic     quiet = 1'b0;

  function automatic void clear_voices();
    for (int i = 0; i < NV; i++) begin
      ages[i] = '0;
      is_active[i] = 1'b0;
      is_held[i] = 1'b0;
      v_note[i] = '0;
      v_chan[i] = '0;
    end
    n_active = 0;
  endfunction

  function automatic void unlink_voice(int v);
    int p;
    p = n_active;
    for (int i = 0; i < n_active; i++) if (ages[i] == v && p == n_active) p = i;
    if (p == n_active) return;
    for (int k = p; k + 1 < n_active; k++) ages[k] = ages[k + 1];
    n_active--;
  endfunction

  function automatic outcome_t allocate_voice(command_t c);
    outcome_t r;
    int v;
    r = '0;
    r.status = pva_pkg::ST_NOMATCH;
    case (c.cmd)
      pva_pkg::CMD_NOTE_ON: begin
        if (c.channel < NCH) begin
          if (n_active >= NV) begin
            v = ages[0];
            is_active[v] = 1'b0;
            is_held[v] = 1'b0;
            unlink_voice(v);
            r.status = pva_pkg::ST_STOLEN;
          end else begin
            v = 0;
            while (v < NV && is_active[v]) v++;
            if (v >= NV) v = 0;
            r.status = pva_pkg::ST_FREE;
          end
          v_note[v] = c.note;
          v_chan[v] = c.channel;
          is_held[v] = 1'b1;
          is_active[v] = 1'b1;
          ages[n_active] = v[3:0];
          n_active++;
          r.voice_id = v[3:0];
          r.velocity_out = c.velocity;
          r.fixed_pitch_out = c.fixed_pitch;
        end
      end
      pva_pkg::CMD_NOTE_OFF: begin
        // Newest first; a voice that was already released still matches.
        for (int i = n_active - 1; i >= 0; i--) begin
          v = ages[i];
          if (r.status == pva_pkg::ST_NOMATCH && v_chan[v] == c.channel &&
              v_note[v] == c.note) begin
            is_held[v] = 1'b0;
            r.status = pva_pkg::ST_RELEASED;
            r.voice_id = v[3:0];
          end
        end
      end
      pva_pkg::CMD_END: begin
        r.voice_id = c.ended_voice;
        if (c.ended_voice < NV && is_active[c.ended_voice]) begin
          is_active[c.ended_voice] = 1'b0;
          is_held[c.ended_voice] = 1'b0;
          unlink_voice(c.ended_voice);
          r.status = pva_pkg::ST_ENDED;
        end
      end
      default: begin
        clear_voices();
        r.status = pva_pkg::ST_KILLED;
      end
    endcase
    r.voice_count = n_active[4:0];
    return r;
  endfunction

  // Results are sampled at the edge that ends their strobe cycle.
  always @(posedge clk) begin
    outcome_t got, want;
    if (!rst && done) begin
      got = {status, voice_id, voice_count, velocity_out, fixed_pitch_out};
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status)
          $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        if (got.voice_id !== want.voice_id)
          $display("%0t: voice_id expected %0d actual %0d", $time, want.voice_id,
                   got.voice_id);
        if (got.voice_count !== want.voice_count)
          $display("%0t: voice_count expected %0d actual %0d", $time, want.voice_count,
                   got.voice_count);
        if (got.velocity_out !== want.velocity_out)
          $display("%0t: velocity_out expected %0d actual %0d", $time, want.velocity_out,
                   got.velocity_out);
        if (got.fixed_pitch_out !== want.fixed_pitch_out)
          $display("%0t: fixed_pitch_out expected %0d actual %0d", $time,
                   want.fixed_pitch_out, got.fixed_pitch_out);
        if (got !== want) errors++;
      end
    end
  end

  // Issues one command transaction and waits for the edge that accepts it.
  // The predictor runs on acceptance, so its order matches the hardware.
  // Start stays high from one transaction to the next unless an idle gap is taken.
  task automatic issue_command(command_t c, logic known, outcome_t known_res);
    outcome_t r;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    start <= 1'b1;
    {cmd, note, channel, velocity, fixed_pitch, ended_voice} <= c;
    do @(posedge clk); while (busy);
    r = allocate_voice(c);
    if (known && r !== known_res) begin
      $display("%0t: table row expected %h, predictor %h", $time, known_res, r);
      errors++;
    end
    pending_results.push_back(r);
  endtask

  function automatic command_t rand_command();
    command_t c;
    int pick;
    c = command_t'({$urandom, $urandom});
    pick = $urandom_range(0, 99);
    // Mostly note-on and note-off on a small note pool so that releases match
    // and the pool fills up to the stealing point; end mostly hits live voices.
    if (pick < 45) c.cmd = pva_pkg::CMD_NOTE_ON;
    else if (pick < 75) c.cmd = pva_pkg::CMD_NOTE_OFF;
    else if (pick < 98) c.cmd = pva_pkg::CMD_END;
    else c.cmd = pva_pkg::CMD_KILL;
    if ($urandom_range(0, 3) != 0) begin
      c.note = 7'd60 + 7'($urandom_range(0, 5));
      c.channel = 4'($urandom_range(0, 2));
    end
    if (c.cmd == pva_pkg::CMD_END && n_active > 0 && $urandom_range(0, 3) != 0)
      c.ended_voice = ages[$urandom_range(0, n_active - 1)];
    return c;
  endfunction

  localparam int NROWS = 24;
  row_t directed[NROWS];

  function automatic row_t mk(logic [1:0] op, int nt, int ch, int vel, int fp, int ev,
                              logic known, int st, int vid, int cnt, int vo, int fo);
    row_t r;
    r.cmd = '{op, 7'(nt), 4'(ch), 7'(vel), 1'(fp), 4'(ev)};
    r.known = known;
    r.res = '{3'(st), 4'(vid), 5'(cnt), 7'(vo), 1'(fo)};
    return r;
  endfunction

  initial begin
    command_t c;
    int k;
    clear_voices();
    // Directed table: empty-state cases, extremes, duplicates, kill and refill.
    directed[0] = mk(pva_pkg::CMD_NOTE_OFF, 127, 15, 0, 0, 0, 1, pva_pkg::ST_NOMATCH,
                     0, 0, 0, 0);
    directed[1] = mk(pva_pkg::CMD_END, 0, 0, 0, 0, 15, 1, pva_pkg::ST_NOMATCH,
                     15, 0, 0, 0);
    directed[2] = mk(pva_pkg::CMD_NOTE_ON, 0, 0, 127, 1, 0, 1, pva_pkg::ST_FREE,
                     0, 1, 127, 1);
    directed[3] = mk(pva_pkg::CMD_NOTE_ON, 127, 15, 0, 0, 5, 1, pva_pkg::ST_FREE,
                     1, 2, 0, 0);
    directed[4] = mk(pva_pkg::CMD_NOTE_ON, 127, 15, 85, 1, 0, 1, pva_pkg::ST_FREE,
                     2, 3, 85, 1);
    directed[5] = mk(pva_pkg::CMD_NOTE_OFF, 127, 15, 9, 1, 3, 1, pva_pkg::ST_RELEASED,
                     2, 3, 0, 0);
    directed[6] = mk(pva_pkg::CMD_NOTE_OFF, 127, 15, 0, 0, 0, 1, pva_pkg::ST_RELEASED,
                     2, 3, 0, 0);
    directed[7] = mk(pva_pkg::CMD_NOTE_OFF, 127, 14, 0, 0, 0, 1, pva_pkg::ST_NOMATCH,
                     0, 3, 0, 0);
    directed[8] = mk(pva_pkg::CMD_END, 0, 0, 0, 0, 0, 1, pva_pkg::ST_ENDED,
                     0, 2, 0, 0);
    directed[9] = mk(pva_pkg::CMD_END, 0, 0, 0, 0, 0, 1, pva_pkg::ST_NOMATCH,
                     0, 2, 0, 0);
    directed[10] = mk(pva_pkg::CMD_NOTE_ON, 42, 7, 42, 0, 0, 1, pva_pkg::ST_FREE,
                      0, 3, 42, 0);
    directed[11] = mk(pva_pkg::CMD_KILL, 1, 1, 1, 1, 1, 1, pva_pkg::ST_KILLED,
                      0, 0, 0, 0);
    directed[12] = mk(pva_pkg::CMD_NOTE_OFF, 42, 7, 0, 0, 0, 1, pva_pkg::ST_NOMATCH,
                      0, 0, 0, 0);
    for (int i = 13; i < NROWS; i++)  // fill toward stealing, checked by predictor
      directed[i] = mk(pva_pkg::CMD_NOTE_ON, 20 + i, i % 16, i, i % 2, 0, 0, 0, 0, 0, 0, 0);
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[i]) issue_command(directed[i].cmd, directed[i].known, directed[i].res);
    // Fill all voices, then steal repeatedly, and end the newest voice.
    for (int i = 0; i < 20; i++) begin
      c = rand_command();
      c.cmd = pva_pkg::CMD_NOTE_ON;
      issue_command(c, 1'b0, '0);
    end
    c = rand_command();
    c.cmd = pva_pkg::CMD_END;
    c.ended_voice = ages[NV - 1];
    issue_command(c, 1'b0, '0);
    for (k = 0; k < 1800; k++) begin
      quiet = (k > 1500);
      c = rand_command();
      issue_command(c, 1'b0, '0);
    end
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0)
      $display("polyphonic_voice_allocator_core_test passed");
    else
      $display("polyphonic_voice_allocator_core_test failed");
    $finish;
  end

  initial begin
    #20000000;
    $display("polyphonic_voice_allocator_core_test failed");
    $finish;
  end
endmodule
